// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants for the LRU cache simulator
// Holds the access codes, register indexes, controller states and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAY_COUNT  = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  localparam logic [2:0] AGE_MAX = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUTPUT
  } salc_state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic show;
    logic clear_out;
  } salc_cmd_t;

endpackage

// ===== rtl/salc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salc_ctrl: sequencing of one access
// Captures an item, lets the set read settle, commits the update and holds
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module salc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               clearing,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output salc_pkg::salc_cmd_t cmd
);
  import salc_pkg::*;

  salc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid && !clearing) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUTPUT;
      ST_OUTPUT: begin
        if (out_ready) state_next = in_valid ? ST_READ : ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = !clearing;
        cmd.capture = in_valid & !clearing;
      end
      ST_READ:   ;
      ST_UPDATE: cmd.update = 1'b1;
      ST_OUTPUT: begin
        out_valid   = 1'b1;
        in_ready    = out_ready;
        cmd.capture = out_ready & in_valid;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/salc_datapath.sv =====
// ----------------------------------------------------------------------------
// salc_datapath: set store, tag compare, LRU ranks and running totals
// Each set is one memory row of tags, one row of valid bits and one row of
// ages; a clearing pass after reset empties the valid and age rows.
// ----------------------------------------------------------------------------
module salc_datapath #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  salc_pkg::salc_cmd_t cmd,
  input  logic [2:0]          set_bits,
  input  logic [3:0]          way_count,
  input  logic [5:0]          block_bits,
  input  logic [1:0]          op,
  input  logic [63:0]         address,
  output logic                clearing,
  output logic [1:0]          hit_count,
  output logic                was_miss,
  output logic                was_eviction,
  output logic [31:0]         total_hits,
  output logic [31:0]         total_misses,
  output logic [31:0]         total_evictions
);
  import salc_pkg::*;

  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int SW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CW   = $clog2(MAX_WAYS + 1);

  logic [63:0]           tag_mem   [SETS][MAX_WAYS];
  logic [MAX_WAYS-1:0]   valid_mem [SETS];
  logic [3*MAX_WAYS-1:0] age_mem   [SETS];

  logic [SW-1:0]         set_idx;
  logic [63:0]           tag;
  logic [1:0]            op_q;
  logic [63:0]           rd_tag [MAX_WAYS];
  logic [MAX_WAYS-1:0]   rd_vld;
  logic [3*MAX_WAYS-1:0] rd_age;
  logic [CW-1:0]         ways;
  logic [SW-1:0]         clr_idx;

  // Item capture: split the address once and register it.
  logic [63:0] blk;
  logic [3:0]  sb;
  always_comb begin
    blk = address >> block_bits;
    sb  = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      set_idx <= SW'(blk & ((64'd1 << sb) - 64'd1));
      tag     <= blk >> sb;
    end
  end

  always_comb begin
    if (way_count == 4'd0) ways = CW'(1);
    else if ({1'b0, way_count} > 5'(MAX_WAYS)) ways = CW'(MAX_WAYS);
    else ways = CW'(way_count);
  end

  // Clearing pass: one set row per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + SW'(1);
      if (clr_idx == SW'(SETS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < MAX_WAYS; w++) rd_tag[w] <= tag_mem[set_idx][w];
    rd_vld <= valid_mem[set_idx];
    rd_age <= age_mem[set_idx];
  end

  // Lookup and victim choice over the registered row.
  logic [MAX_WAYS-1:0] vld;
  logic [2:0]    age [MAX_WAYS];
  logic          hit, have_free;
  logic [WW-1:0] hit_w, free_w, best_w, found;
  always_comb begin
    vld = rd_vld;
    for (int w = 0; w < MAX_WAYS; w++) age[w] = rd_age[3*w +: 3];
    hit = 1'b0; hit_w = '0; have_free = 1'b0; free_w = '0; best_w = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (CW'(w) < ways && vld[w] && rd_tag[w] == tag) begin
        hit = 1'b1; hit_w = WW'(w);
      end
      if (CW'(w) < ways && !vld[w]) begin
        have_free = 1'b1; free_w = WW'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (CW'(w) < ways && age[w] > age[best_w]) best_w = WW'(w);
    end
    found = hit ? hit_w : (have_free ? free_w : best_w);
  end

  // New ranks: the touched way becomes zero; valid ways younger than its
  // old rank (a fresh fill counts as the oldest) age by one, saturating.
  logic [2:0]            old_age;
  logic [2:0]            new_age [MAX_WAYS];
  logic [MAX_WAYS-1:0]   vld_new;
  logic [3*MAX_WAYS-1:0] age_row_new;
  logic                  evict;
  always_comb begin
    evict   = !hit && !have_free;
    old_age = (!hit && have_free) ? AGE_MAX : age[found];
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_age[w] = age[w];
      if (CW'(w) < ways && WW'(w) != found && vld[w] &&
          age[w] < old_age && age[w] < AGE_MAX)
        new_age[w] = age[w] + 3'd1;
    end
    new_age[found] = 3'd0;
    vld_new = vld;
    vld_new[found] = 1'b1;
    for (int w = 0; w < MAX_WAYS; w++) age_row_new[3*w +: 3] = new_age[w];
  end

  logic [1:0] hits;
  always_comb hits = 2'(hit) + 2'(op_q == OP_MODIFY);

  always_ff @(posedge clk) begin
    if (cmd.update && !hit) tag_mem[set_idx][found] <= tag;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_idx] <= '0;
      age_mem[clr_idx]   <= '0;
    end else if (cmd.update) begin
      valid_mem[set_idx] <= vld_new;
      age_mem[set_idx]   <= age_row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_hits <= '0; total_misses <= '0; total_evictions <= '0;
    end else if (cmd.update) begin
      total_hits      <= total_hits + 32'(hits);
      total_misses    <= total_misses + 32'(!hit);
      total_evictions <= total_evictions + 32'(evict);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_count    <= hits;
      was_miss     <= !hit;
      was_eviction <= evict;
    end
  end

endmodule

// ===== rtl/set_assoc_lru_cache_sim_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit: set-associative LRU cache hit/miss counter
// Top level joining the configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage: each item on the input channel (op, address) is one data access.
// The block returns one item per access on the output channel, giving the
// hit count, miss and eviction flags and the running totals after it.
// After acceptance an item passes through a read state, which brings the
// set's rows from memory into registers, and an update state, which compares
// and commits the new ranks; the result then sits in the output register. A
// new item is accepted in the same cycle the result is taken, and not before,
// since each item makes a single read-then-write pass over the set memory.
// A modify's second access reuses the same line and needs no second pass.
// When the receiver stalls, the result is held and no new item is taken.
// Reset clears the totals and starts a clearing pass that empties the valid
// bits and LRU ranks of one set per cycle over all 2^MAX_SET_BITS sets (64 by
// default); in_ready stays low until it ends. The registers return to a set
// bit count of zero, one way and zero block bits. Configuration is to be
// written through cfg_we, cfg_index and cfg_data only while idle, which the
// block does not enforce; unknown indexes are ignored, lines kept across reconfiguration.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  hit_count,
  output logic        was_miss,
  output logic        was_eviction,
  output logic [31:0] total_hits,
  output logic [31:0] total_misses,
  output logic [31:0] total_evictions
);
  import salc_pkg::*;

  logic [2:0] set_bits;
  logic [3:0] way_count;
  logic [5:0] block_bits;

  // Configuration registers; writes to an unknown index fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd0;
      way_count  <= 4'd1;
      block_bits <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS:   set_bits   <= cfg_data[2:0];
        REG_WAY_COUNT:  way_count  <= cfg_data[3:0];
        REG_BLOCK_BITS: block_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  salc_cmd_t cmd;
  logic      clearing;

  salc_ctrl u_ctrl (
    .clk, .rst, .clearing, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  salc_datapath #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk, .rst, .cmd, .set_bits, .way_count, .block_bits, .op, .address,
    .clearing, .hit_count, .was_miss, .was_eviction,
    .total_hits, .total_misses, .total_evictions
  );

endmodule

// ===== rtl/salc_checker.sv =====
// ----------------------------------------------------------------------------
// salc_checker: port-level checks for the cache simulator
// Watches the handshakes and the result fields of the top level.
// ----------------------------------------------------------------------------
module salc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  hit_count,
  input logic        was_miss,
  input logic        was_eviction,
  input logic [31:0] total_misses
);

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // An eviction only happens on a miss.
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_eviction |-> was_miss) else $error("eviction without miss");

  // A miss gives at most one hit, from a modify's second access.
  a_miss_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_miss |-> hit_count != 2'd2) else $error("bad hit count");

  // An accepted item never yields a result in the very next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid) else $error("early result");

  // Totals move only while a result is being formed, not while one waits.
  a_total_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(total_misses)) else $error("total moved");

endmodule

bind set_assoc_lru_cache_sim_unit salc_checker u_salc_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .hit_count, .was_miss, .was_eviction, .total_misses
);
